>>> rtl/core/tgmr_pkg.sv
// Shared types, constants and codes of the touch gesture mouse recognizer.
package tgmr_pkg;

    localparam int MAX_SLOTS        = 5;
    localparam int DEF_FINGER_SLOTS = 5;
    localparam int DEF_COORD_BITS   = 12;

    localparam int COORD_W      = 12;
    localparam int COUNT_W      = 3;
    localparam int TIME_W       = 32;
    localparam int MOVE_LIMIT_W = 13;
    localparam int TIME_LIMIT_W = 16;
    localparam int GAIN_W       = 8;
    localparam int GAIN_FRAC    = 4;
    localparam int MOVE_W       = 8;
    localparam int MOVE_MAX     = 127;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TAP_MOVE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAP_TIME  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MOVE_GAIN = 2'd2;

    localparam logic [MOVE_LIMIT_W-1:0] RST_TAP_MOVE  = 13'd10;
    localparam logic [TIME_LIMIT_W-1:0] RST_TAP_TIME  = 16'd200;
    localparam logic [GAIN_W-1:0]       RST_MOVE_GAIN = 8'd16;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_MOVE  = 2'd1,
        EV_CLICK = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        BTN_LEFT   = 2'd0,
        BTN_RIGHT  = 2'd1,
        BTN_MIDDLE = 2'd2
    } button_t;

    typedef struct packed {
        logic [COUNT_W-1:0] touch_count;
        logic [TIME_W-1:0]  time_ms;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
        logic [COORD_W-1:0] x3;
        logic [COORD_W-1:0] y3;
        logic [COORD_W-1:0] x4;
        logic [COORD_W-1:0] y4;
    } in_item_t;

    typedef struct packed {
        event_kind_t               event_kind;
        logic signed [MOVE_W-1:0]  move_dx;
        logic signed [MOVE_W-1:0]  move_dy;
        button_t                   button;
    } out_item_t;

    typedef struct packed {
        logic [MOVE_LIMIT_W-1:0] tap_move_limit;
        logic [TIME_LIMIT_W-1:0] tap_time_limit;
        logic [GAIN_W-1:0]       move_gain;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_SCALE,
        ST_CHECK,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic scale;
        logic check;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic lift;
        logic check_done;
        logic out_busy;
    } dp_status_t;

endpackage

>>> rtl/core/touch_gesture_mouse_recognizer.sv
// Top level of the trackpad tap and drag gesture recognizer.
//
// Each item on the touch channel is one multitouch snapshot: finger count,
// millisecond timestamp and five points. Every snapshot yields exactly one
// item on the gesture channel: nothing, a mouse move or a button click.
// Limits and drag gain are written through the APB-style port; the user
// must do so only while idle, as the block itself does not enforce it.
// A snapshot with fingers down passes through capture at acceptance,
// store update, move scaling and output load. A snapshot in which all
// fingers lift runs the tap check one session finger per cycle on a
// shared compare unit, stopping at the first finger that fails, and then
// loads its result into the output register.
// The next snapshot is accepted once the previous result enters the
// output register, even while that result still waits to be taken.
// If the receiver stalls, the result holds in the output register and the
// block stops before loading the following result.
// Reset restores the register defaults, clears the finger store and the
// session, and empties the output register.
module touch_gesture_mouse_recognizer #(
    parameter int FINGER_SLOTS = tgmr_pkg::DEF_FINGER_SLOTS,
    parameter int COORD_BITS   = tgmr_pkg::DEF_COORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        touch_valid,
    output logic                        touch_ready,
    input  tgmr_pkg::in_item_t          touch_item,
    output logic                        gesture_valid,
    input  logic                        gesture_ready,
    output tgmr_pkg::out_item_t         gesture_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tgmr_pkg::ADDR_W-1:0] paddr,
    input  logic [tgmr_pkg::DATA_W-1:0] pwdata,
    output logic [tgmr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tgmr_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    tgmr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgmr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .touch_valid (touch_valid),
        .touch_ready (touch_ready),
        .status      (status),
        .cmd         (cmd)
    );

    tgmr_dpath #(
        .FINGER_SLOTS (FINGER_SLOTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .touch_item    (touch_item),
        .cfg           (cfg),
        .cmd           (cmd),
        .gesture_ready (gesture_ready),
        .status        (status),
        .gesture_valid (gesture_valid),
        .gesture_item  (gesture_item)
    );

    // At most one datapath command is issued in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.scale, cmd.check, cmd.emit}))
        else $error("more than one datapath command at once");

    // A new result never overwrites one the receiver has not yet taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_busy)
        else $error("result loaded over a pending output item");

    // A loaded result is presented in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> gesture_valid)
        else $error("loaded result not presented");

    // One snapshot is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        touch_valid && touch_ready |=> !touch_ready)
        else $error("second item accepted while one is in work");

endmodule

>>> rtl/core/tgmr_regs.sv
// Configuration register file with its APB-style access port.
module tgmr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tgmr_pkg::ADDR_W-1:0] paddr,
    input  logic [tgmr_pkg::DATA_W-1:0] pwdata,
    output logic [tgmr_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output tgmr_pkg::cfg_t              cfg
);
    import tgmr_pkg::*;

    logic [MOVE_LIMIT_W-1:0] tap_move_limit_reg;
    logic [TIME_LIMIT_W-1:0] tap_time_limit_reg;
    logic [GAIN_W-1:0]       move_gain_reg;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_move_limit_reg <= RST_TAP_MOVE;
            tap_time_limit_reg <= RST_TAP_TIME;
            move_gain_reg      <= RST_MOVE_GAIN;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TAP_MOVE:  tap_move_limit_reg <= pwdata[MOVE_LIMIT_W-1:0];
                REG_TAP_TIME:  tap_time_limit_reg <= pwdata[TIME_LIMIT_W-1:0];
                REG_MOVE_GAIN: move_gain_reg      <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TAP_MOVE:  prdata = DATA_W'(tap_move_limit_reg);
            REG_TAP_TIME:  prdata = DATA_W'(tap_time_limit_reg);
            REG_MOVE_GAIN: prdata = DATA_W'(move_gain_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.tap_move_limit = tap_move_limit_reg;
    assign cfg.tap_time_limit = tap_time_limit_reg;
    assign cfg.move_gain      = move_gain_reg;

endmodule

>>> rtl/core/tgmr_ctrl.sv
// Sequencing state machine that issues datapath commands for each item.
module tgmr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   touch_valid,
    output logic                   touch_ready,
    input  tgmr_pkg::dp_status_t   status,
    output tgmr_pkg::dp_cmd_t      cmd
);
    import tgmr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (touch_valid)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:  state_next = status.lift ? ST_CHECK : ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_CHECK:
            begin
                if (status.check_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        touch_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                touch_ready = 1'b1;
                cmd.load    = touch_valid;
            end
            ST_STEP:  cmd.step  = 1'b1;
            ST_SCALE: cmd.scale = 1'b1;
            ST_CHECK: cmd.check = 1'b1;
            ST_DONE:  cmd.emit  = !status.out_busy;
            default: ;
        endcase
    end

endmodule

>>> rtl/core/tgmr_dpath.sv
// Finger store, drag tracking, move scaling, tap check and output register.
module tgmr_dpath #(
    parameter int FINGER_SLOTS = tgmr_pkg::DEF_FINGER_SLOTS,
    parameter int COORD_BITS   = tgmr_pkg::DEF_COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tgmr_pkg::in_item_t    touch_item,
    input  tgmr_pkg::cfg_t        cfg,
    input  tgmr_pkg::dp_cmd_t     cmd,
    input  logic                  gesture_ready,
    output tgmr_pkg::dp_status_t  status,
    output logic                  gesture_valid,
    output tgmr_pkg::out_item_t   gesture_item
);
    import tgmr_pkg::*;

    localparam int CW      = COORD_BITS;
    localparam int DW      = CW + 1;
    localparam int SUMW    = CW + 1;
    localparam int CMPW    = (SUMW > MOVE_LIMIT_W) ? SUMW : MOVE_LIMIT_W;
    localparam int PRODW   = CW + GAIN_W;
    localparam int QW      = PRODW - GAIN_FRAC;
    localparam int SLOT_IW = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic signed [MOVE_W-1:0] scale_move(input logic signed [DW-1:0] d,
                                                            input logic [GAIN_W-1:0] gain);
        logic [CW-1:0]            mag;
        logic [PRODW-1:0]         prod;
        logic [QW-1:0]            q;
        logic signed [MOVE_W-1:0] sat;
        mag  = d[DW-1] ? CW'(-d) : CW'(d);
        prod = PRODW'(mag) * PRODW'(gain);
        q    = prod[PRODW-1:GAIN_FRAC];
        sat  = (q > QW'(MOVE_MAX)) ? MOVE_W'(MOVE_MAX) : MOVE_W'(q);
        return d[DW-1] ? -sat : sat;
    endfunction

    logic [COORD_W-1:0] raw_x [MAX_SLOTS];
    logic [COORD_W-1:0] raw_y [MAX_SLOTS];
    logic [COUNT_W-1:0] count_in;

    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [CW-1:0]      px_reg [FINGER_SLOTS];
    logic [CW-1:0]      py_reg [FINGER_SLOTS];

    logic [COUNT_W-1:0]      prev_reg;
    logic [COUNT_W-1:0]      smax_reg;
    logic [FINGER_SLOTS-1:0] active_reg;
    logic [FINGER_SLOTS-1:0] drag_reg;
    logic [CW-1:0]           sx_reg [FINGER_SLOTS];
    logic [CW-1:0]           sy_reg [FINGER_SLOTS];
    logic [CW-1:0]           lx_reg [FINGER_SLOTS];
    logic [CW-1:0]           ly_reg [FINGER_SLOTS];
    logic [TIME_W-1:0]       st_reg [FINGER_SLOTS];
    logic [COUNT_W-1:0]      idx_reg;

    logic                    move_pend_reg;
    logic signed [DW-1:0]    dx_reg;
    logic signed [DW-1:0]    dy_reg;
    out_item_t               res_reg;
    out_item_t               out_reg;
    logic                    out_valid_reg;

    logic [FINGER_SLOTS-1:0] rec;
    logic                    drag_en;
    logic [SUMW-1:0]         total;
    logic                    over_limit;
    logic signed [DW-1:0]    ddx;
    logic signed [DW-1:0]    ddy;

    logic [SLOT_IW-1:0]      slot;
    logic [SUMW-1:0]         c_moved;
    logic [TIME_W-1:0]       c_held;
    logic                    c_end;
    logic                    c_fail;
    logic                    check_done;
    button_t                 click_btn;

    assign raw_x[0] = touch_item.x0;
    assign raw_y[0] = touch_item.y0;
    assign raw_x[1] = touch_item.x1;
    assign raw_y[1] = touch_item.y1;
    assign raw_x[2] = touch_item.x2;
    assign raw_y[2] = touch_item.y2;
    assign raw_x[3] = touch_item.x3;
    assign raw_y[3] = touch_item.y3;
    assign raw_x[4] = touch_item.x4;
    assign raw_y[4] = touch_item.y4;

    assign count_in = (touch_item.touch_count > COUNT_W'(FINGER_SLOTS)) ?
                      COUNT_W'(FINGER_SLOTS) : touch_item.touch_count;

    // Slots newly covered by the count, and the drag measurement of slot 0.
    always_comb
    begin
        for (int i = 0; i < FINGER_SLOTS; i++)
        begin
            rec[i] = (COUNT_W'(i) >= prev_reg) && (COUNT_W'(i) < count_reg);
        end
    end

    assign drag_en    = (count_reg == COUNT_W'(1)) && (prev_reg != '0) && active_reg[0];
    assign total      = SUMW'(abs_diff(px_reg[0], sx_reg[0])) +
                        SUMW'(abs_diff(py_reg[0], sy_reg[0]));
    assign over_limit = CMPW'(total) > CMPW'(cfg.tap_move_limit);
    assign ddx        = signed'({1'b0, px_reg[0]}) - signed'({1'b0, lx_reg[0]});
    assign ddy        = signed'({1'b0, py_reg[0]}) - signed'({1'b0, ly_reg[0]});

    // Tap check of one session slot per cycle.
    assign slot       = idx_reg[SLOT_IW-1:0];
    assign c_moved    = SUMW'(abs_diff(lx_reg[slot], sx_reg[slot])) +
                        SUMW'(abs_diff(ly_reg[slot], sy_reg[slot]));
    assign c_held     = time_reg - st_reg[slot];
    assign c_end      = idx_reg >= smax_reg;
    assign c_fail     = !c_end && ((CMPW'(c_moved) > CMPW'(cfg.tap_move_limit)) ||
                                   (c_held > TIME_W'(cfg.tap_time_limit)));
    assign check_done = c_end || c_fail;

    always_comb
    begin
        case (smax_reg)
            COUNT_W'(1): click_btn = BTN_LEFT;
            COUNT_W'(2): click_btn = BTN_RIGHT;
            default:     click_btn = BTN_MIDDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            count_reg <= count_in;
            time_reg  <= touch_item.time_ms;
            for (int i = 0; i < FINGER_SLOTS; i++)
            begin
                px_reg[i] <= CW'(raw_x[i]);
                py_reg[i] <= CW'(raw_y[i]);
            end
        end
        if (cmd.step)
        begin
            dx_reg <= ddx;
            dy_reg <= ddy;
        end
        if (cmd.scale)
        begin
            res_reg.event_kind <= move_pend_reg ? EV_MOVE : EV_NONE;
            res_reg.move_dx    <= move_pend_reg ? scale_move(dx_reg, cfg.move_gain) : '0;
            res_reg.move_dy    <= move_pend_reg ? scale_move(dy_reg, cfg.move_gain) : '0;
            res_reg.button     <= BTN_LEFT;
        end
        if (cmd.check && check_done)
        begin
            res_reg.event_kind <= c_end ? EV_CLICK : EV_NONE;
            res_reg.move_dx    <= '0;
            res_reg.move_dy    <= '0;
            res_reg.button     <= c_end ? click_btn : BTN_LEFT;
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            smax_reg      <= '0;
            active_reg    <= '0;
            drag_reg      <= '0;
            idx_reg       <= '0;
            move_pend_reg <= 1'b0;
            for (int i = 0; i < FINGER_SLOTS; i++)
            begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                lx_reg[i] <= '0;
                ly_reg[i] <= '0;
                st_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.step)
            begin
                prev_reg <= count_reg;
                idx_reg  <= '0;
                if ((count_reg > prev_reg) && (count_reg > smax_reg))
                begin
                    smax_reg <= count_reg;
                end
                for (int i = 0; i < FINGER_SLOTS; i++)
                begin
                    if (rec[i])
                    begin
                        active_reg[i] <= 1'b1;
                        drag_reg[i]   <= 1'b0;
                        sx_reg[i]     <= px_reg[i];
                        sy_reg[i]     <= py_reg[i];
                        lx_reg[i]     <= px_reg[i];
                        ly_reg[i]     <= py_reg[i];
                        st_reg[i]     <= time_reg;
                    end
                end
                if (drag_en)
                begin
                    lx_reg[0] <= px_reg[0];
                    ly_reg[0] <= py_reg[0];
                    if (over_limit)
                    begin
                        drag_reg[0] <= 1'b1;
                    end
                end
                move_pend_reg <= drag_en && (drag_reg[0] || over_limit) &&
                                 ((ddx != '0) || (ddy != '0));
            end
            if (cmd.check)
            begin
                if (check_done)
                begin
                    smax_reg   <= '0;
                    active_reg <= '0;
                    drag_reg   <= '0;
                    for (int i = 0; i < FINGER_SLOTS; i++)
                    begin
                        sx_reg[i] <= '0;
                        sy_reg[i] <= '0;
                        lx_reg[i] <= '0;
                        ly_reg[i] <= '0;
                        st_reg[i] <= '0;
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (gesture_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.lift       = (prev_reg != '0) && (count_reg == '0);
    assign status.check_done = check_done;
    assign status.out_busy   = out_valid_reg && !gesture_ready;

    assign gesture_valid = out_valid_reg;
    assign gesture_item  = out_reg;

endmodule

>>> bench/tb_touch_gesture_mouse_recognizer.sv
// Self-checking testbench for the touch gesture mouse recognizer.
`timescale 1ns / 1ps

import tgmr_pkg::*;

class gesture_scoreboard;
    logic [MOVE_LIMIT_W-1:0] move_limit;
    logic [TIME_LIMIT_W-1:0] time_limit;
    logic [GAIN_W-1:0]       gain;
    int                      prev_count;
    int                      session_max;
    bit                      active[MAX_SLOTS];
    bit                      dragging[MAX_SLOTS];
    int                      start_x[MAX_SLOTS];
    int                      start_y[MAX_SLOTS];
    int                      last_x[MAX_SLOTS];
    int                      last_y[MAX_SLOTS];
    logic [TIME_W-1:0]       press_ms[MAX_SLOTS];
    out_item_t               pending[$];
    int                      mismatches;

    function new();
        move_limit  = RST_TAP_MOVE;
        time_limit  = RST_TAP_TIME;
        gain        = RST_MOVE_GAIN;
        prev_count  = 0;
        session_max = 0;
        mismatches  = 0;
        clear_store();
    endfunction

    function void clear_store();
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            active[i]   = 1'b0;
            dragging[i] = 1'b0;
            start_x[i]  = 0;
            start_y[i]  = 0;
            last_x[i]   = 0;
            last_y[i]   = 0;
            press_ms[i] = '0;
        end
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        case (idx)
            REG_TAP_MOVE:  move_limit = value[MOVE_LIMIT_W-1:0];
            REG_TAP_TIME:  time_limit = value[TIME_LIMIT_W-1:0];
            REG_MOVE_GAIN: gain = value[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    function int span(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function int scale_delta(int d);
        int mag;
        int q;
        mag = (d < 0) ? -d : d;
        q = (mag * int'(gain)) >>> GAIN_FRAC;
        if (q > MOVE_MAX)
            q = MOVE_MAX;
        return (d < 0) ? -q : q;
    endfunction

    function void note_snapshot(in_item_t snap);
        int        px[MAX_SLOTS];
        int        py[MAX_SLOTS];
        int        count;
        int        dx;
        int        dy;
        int        moved;
        logic [TIME_W-1:0] held;
        bit        tap;
        out_item_t expected;
        px[0] = int'(snap.x0); py[0] = int'(snap.y0);
        px[1] = int'(snap.x1); py[1] = int'(snap.y1);
        px[2] = int'(snap.x2); py[2] = int'(snap.y2);
        px[3] = int'(snap.x3); py[3] = int'(snap.y3);
        px[4] = int'(snap.x4); py[4] = int'(snap.y4);
        count = int'(snap.touch_count);
        if (count > MAX_SLOTS)
            count = MAX_SLOTS;
        expected = '0;
        expected.event_kind = EV_NONE;
        expected.button = BTN_LEFT;

        for (int i = prev_count; i < count; i++)
        begin
            active[i]   = 1'b1;
            dragging[i] = 1'b0;
            start_x[i]  = px[i];
            last_x[i]   = px[i];
            start_y[i]  = py[i];
            last_y[i]   = py[i];
            press_ms[i] = snap.time_ms;
            if (i + 1 > session_max)
                session_max = i + 1;
        end

        if (count == 1 && active[0])
        begin
            dx = px[0] - last_x[0];
            dy = py[0] - last_y[0];
            moved = span(px[0], start_x[0]) + span(py[0], start_y[0]);
            if (moved > int'(move_limit))
                dragging[0] = 1'b1;
            if (dragging[0] && (dx != 0 || dy != 0))
            begin
                expected.event_kind = EV_MOVE;
                expected.move_dx = MOVE_W'(scale_delta(dx));
                expected.move_dy = MOVE_W'(scale_delta(dy));
            end
            last_x[0] = px[0];
            last_y[0] = py[0];
        end

        if (prev_count > 0 && count == 0)
        begin
            tap = 1'b1;
            for (int i = 0; i < session_max; i++)
            begin
                moved = span(last_x[i], start_x[i]) + span(last_y[i], start_y[i]);
                held = snap.time_ms - press_ms[i];
                if (moved > int'(move_limit) || held > TIME_W'(time_limit))
                begin
                    tap = 1'b0;
                    break;
                end
            end
            if (tap)
            begin
                expected.event_kind = EV_CLICK;
                if (session_max == 1)
                    expected.button = BTN_LEFT;
                else if (session_max == 2)
                    expected.button = BTN_RIGHT;
                else
                    expected.button = BTN_MIDDLE;
            end
            session_max = 0;
            clear_store();
        end

        prev_count = count;
        pending.push_back(expected);
    endfunction

    function void check_gesture(out_item_t got);
        out_item_t expected;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected gesture item: kind %0d dx %0d dy %0d button %0d",
                         got.event_kind, got.move_dx, got.move_dy, got.button);
            return;
        end
        expected = pending.pop_front();
        if (got.event_kind !== expected.event_kind || got.move_dx !== expected.move_dx ||
            got.move_dy !== expected.move_dy || got.button !== expected.button)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("Gesture mismatch: expected kind %0d dx %0d dy %0d button %0d,",
                       expected.event_kind, expected.move_dx, expected.move_dy,
                       expected.button);
                $display(" got kind %0d dx %0d dy %0d button %0d",
                         got.event_kind, got.move_dx, got.move_dy, got.button);
            end
        end
    endfunction
endclass

module tb_touch_gesture_mouse_recognizer;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  touch_valid = 1'b0;
    logic                  touch_ready;
    in_item_t              touch_item = '0;
    logic                  gesture_valid;
    logic                  gesture_ready = 1'b0;
    out_item_t             gesture_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    gesture_scoreboard     board = new();
    int                    items_sent = 0;
    int                    burst_left = 0;
    bit                    hold_request = 1'b0;
    logic [TIME_W-1:0]     clock_ms = 32'd10000;

    touch_gesture_mouse_recognizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .touch_valid   (touch_valid),
        .touch_ready   (touch_ready),
        .touch_item    (touch_item),
        .gesture_valid (gesture_valid),
        .gesture_ready (gesture_ready),
        .gesture_item  (gesture_item),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && gesture_valid && gesture_ready)
            board.check_gesture(gesture_item);
    end

    initial
    begin
        int  mode;
        int  seg_left;
        int  stall_left;
        bit  ready_next;
        mode = 0;
        seg_left = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = 300;
            end
            if (seg_left == 0)
            begin
                mode = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 96);
            end
            seg_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (mode)
                    0: ready_next = 1'b1;
                    1: ready_next = 1'($urandom_range(0, 1));
                    2: ready_next = (seg_left % 4 == 0);
                    default: ready_next = ($urandom_range(0, 4) != 0);
                endcase
            end
            gesture_ready <= ready_next;
        end
    end

    function automatic in_item_t make_snapshot(int count, logic [TIME_W-1:0] ms,
                                               logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        in_item_t snap;
        snap.touch_count = COUNT_W'(count);
        snap.time_ms = ms;
        snap.x0 = x;
        snap.y0 = y;
        snap.x1 = COORD_W'($urandom);
        snap.y1 = COORD_W'($urandom);
        snap.x2 = COORD_W'($urandom);
        snap.y2 = COORD_W'($urandom);
        snap.x3 = COORD_W'($urandom);
        snap.y3 = COORD_W'($urandom);
        snap.x4 = COORD_W'($urandom);
        snap.y4 = COORD_W'($urandom);
        return snap;
    endfunction

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic offer(input in_item_t snap);
        int gap;
        touch_item <= snap;
        touch_valid <= 1'b1;
        @(posedge clk);
        while (!touch_ready)
            @(posedge clk);
        board.note_snapshot(snap);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                touch_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_register(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input int move_limit, input int time_limit, input int gain);
        touch_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        write_reg(REG_TAP_MOVE, DATA_W'(move_limit));
        write_reg(REG_TAP_TIME, DATA_W'(time_limit));
        write_reg(REG_MOVE_GAIN, DATA_W'(gain));
    endtask

    function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c, int d);
        return c + COORD_W'(d);
    endfunction

    task automatic random_session();
        int                 style;
        int                 fingers;
        int                 steps;
        int                 hold;
        int                 count;
        int                 reach;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIME_W-1:0]  t0;
        style = $urandom_range(0, 9);
        case ($urandom_range(0, 15))
            0: clock_ms = $urandom;
            1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
            default: clock_ms = clock_ms + $urandom_range(1, 3000);
        endcase
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        t0 = clock_ms;
        if (style < 4)
        begin
            fingers = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
            steps = $urandom_range(0, 3);
            if ($urandom_range(0, 1))
                hold = $urandom_range(0, int'(board.time_limit));
            else
                hold = int'(board.time_limit) + $urandom_range(0, 30) - 15;
            if (hold < 0)
                hold = 0;
            if (fingers > 1 && $urandom_range(0, 2) == 0)
                offer(make_snapshot($urandom_range(1, fingers - 1), t0, x, y));
            offer(make_snapshot(fingers, t0, x, y));
            for (int k = 1; k <= steps; k++)
            begin
                reach = ($urandom_range(0, 3) == 0) ? 12 : 3;
                x = nudge(x, $urandom_range(0, 2 * reach) - reach);
                y = nudge(y, $urandom_range(0, 2 * reach) - reach);
                count = $urandom_range(0, 1) ? fingers : $urandom_range(1, fingers);
                offer(make_snapshot(count, t0 + TIME_W'((hold * k) / (steps + 1)), x, y));
            end
            clock_ms = t0 + TIME_W'(hold);
            offer(make_snapshot(0, clock_ms, x, y));
        end
        else if (style < 8)
        begin
            steps = $urandom_range(2, 12);
            offer(make_snapshot(1, clock_ms, x, y));
            for (int k = 0; k < steps; k++)
            begin
                clock_ms = clock_ms + $urandom_range(5, 20);
                case ($urandom_range(0, 9))
                    0: ;
                    1:
                    begin
                        x = nudge(x, $urandom_range(0, 8190) - 4095);
                        y = nudge(y, $urandom_range(0, 8190) - 4095);
                    end
                    default:
                    begin
                        x = nudge(x, $urandom_range(0, 80) - 40);
                        y = nudge(y, $urandom_range(0, 80) - 40);
                    end
                endcase
                offer(make_snapshot(1, clock_ms, x, y));
            end
            clock_ms = clock_ms + $urandom_range(5, 20);
            offer(make_snapshot(0, clock_ms, x, y));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                offer(make_snapshot($urandom_range(0, 7), $urandom,
                                    COORD_W'($urandom), COORD_W'($urandom)));
        end
    endtask

    initial
    begin
        int target;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer(in_item_t'({3'd0, 32'd0, {10{12'h000}}}));
        offer(make_snapshot(1, 32'd1000, 12'd100, 12'd100));
        offer(make_snapshot(1, 32'd1050, 12'd103, 12'd104));
        offer(make_snapshot(0, 32'd1100, 12'd103, 12'd104));
        offer(make_snapshot(1, 32'd2000, 12'd200, 12'd200));
        offer(make_snapshot(1, 32'd2100, 12'd205, 12'd205));
        offer(make_snapshot(0, 32'd2200, 12'd205, 12'd205));
        offer(make_snapshot(2, 32'd3000, 12'd300, 12'd300));
        offer(make_snapshot(0, 32'd3050, 12'd300, 12'd300));
        offer(make_snapshot(1, 32'd4000, 12'd400, 12'd400));
        offer(make_snapshot(3, 32'd4010, 12'd400, 12'd400));
        offer(make_snapshot(0, 32'd4100, 12'd400, 12'd400));
        offer(make_snapshot(2, 32'd5000, 12'd500, 12'd500));
        offer(make_snapshot(1, 32'd5010, 12'd500, 12'd500));
        offer(make_snapshot(0, 32'd5050, 12'd500, 12'd500));
        offer(in_item_t'({3'd7, 32'hFFFF_FFF0, {10{12'hFFF}}}));
        offer(make_snapshot(0, 32'h0000_0040, 12'hFFF, 12'hFFF));
        offer(make_snapshot(1, 32'd6000, 12'd0, 12'd0));
        offer(make_snapshot(1, 32'd6010, 12'hFFF, 12'hFFF));
        offer(make_snapshot(1, 32'd6020, 12'd0, 12'd0));
        offer(make_snapshot(1, 32'd6030, 12'd3, 12'd0));
        offer(make_snapshot(1, 32'd6040, 12'd3, 12'd0));
        offer(make_snapshot(0, 32'd6050, 12'd3, 12'd0));
        offer(make_snapshot(1, 32'd7000, 12'd700, 12'd700));
        offer(make_snapshot(0, 32'd7201, 12'd700, 12'd700));

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: ;
                1: apply_setting(0, 0, 255);
                2: apply_setting(8191, 65535, 0);
                3: apply_setting(30, 500, 16);
                4: apply_setting($urandom_range(0, 200), $urandom_range(20, 1000),
                                 $urandom_range(1, 64));
                default: apply_setting($urandom_range(0, 8191), $urandom_range(0, 65535),
                                       $urandom_range(0, 255));
            endcase
            if (phase == 0)
            begin
                hold_request = 1'b1;
                burst_left = 40;
            end
            target = items_sent + 115;
            while (items_sent < target)
                random_session();
        end

        touch_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        board.mismatches += board.pending.size();
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
